### rtl/sfr_pkg.sv
// shared types and constants for the serial frame receiver
// no dependencies; imported by every module of the block

package sfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int STORE_DEPTH_DEF = 64;
  localparam int HEADER_BYTES    = 7;
  localparam int TRAILER_BYTES   = 3;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 16;
  localparam int HIDX_W    = $clog2(HEADER_BYTES);
  localparam int CMP_W     = LEN_W + 2;
  localparam int RAW_W     = 2 * BYTE_W;
  localparam int CFG_IDX_W = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_FIRST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_SECOND  = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [BYTE_W-1:0] sync_third;
    logic [BYTE_W-1:0] end_first;
    logic [BYTE_W-1:0] end_second;
  } cfg_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] msg_class;
    logic [BYTE_W-1:0] msg_kind;
    logic [LEN_W-1:0]  plen;
    logic [CNT_W-1:0]  cerr;
    logic [CNT_W-1:0]  herr;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic has_good;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } bk_state_t;

endpackage

### rtl/serial_frame_receiver_unit.sv
// serial frame receiver: sync header, length and additive checksum deframer
// holds the configuration registers; uses sfr_pkg, sfr_front, sfr_queue, sfr_back
//
// in_* carries one received byte per transaction; out_* carries results: one per
// payload byte of a good frame (last set on the final one), or a single error result
// for a bad checksum or length. cfg_we writes register cfg_addr:
// 0..2 header sync bytes, 3..4 terminator pair; other indexes are ignored.
// a frame is checked when its last terminator byte is taken, from a running sum;
// an error result goes from the idle state straight to the show state, while each
// result of a good frame first passes the fetch state (one payload store read per
// result), so a good frame offers no new result before the store read for it is done.
// the payload store has one write and one read port: a byte at store position 7 or
// beyond waits while a result job is being sent or a good frame is queued, so only
// the 7 header bytes of the next frame are taken during a drain.
// a two-entry job queue sits between the front end and the result side; a header
// byte waits only when it is full. when the receiver stalls, the result on out_*
// holds unchanged and the byte stream stops at the next frame's payload.
// reset is synchronous: framing and hunt state, counters and registers go to zero;
// the store is not cleared and needs no clearing pass.

module serial_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
  parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [sfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [sfr_pkg::BYTE_W-1:0]    out_msg_class,
  output logic [sfr_pkg::BYTE_W-1:0]    out_msg_kind,
  output logic [sfr_pkg::LEN_W-1:0]     out_payload_len,
  output logic [sfr_pkg::IDX_W-1:0]     out_byte_index,
  output logic [sfr_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                          out_last,
  output logic [sfr_pkg::CNT_W-1:0]     out_checksum_errors,
  output logic [sfr_pkg::CNT_W-1:0]     out_header_errors
);
  import sfr_pkg::*;

  localparam int PW = $clog2(STORE_DEPTH);

  cfg_t              cfg_r, cfg_nxt;
  q_stat_t           q_stat;
  job_t              push_job, head;
  logic              push, pop, back_busy;
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SYNC_FIRST:  cfg_nxt.sync_first  = cfg_wdata;
        REG_SYNC_SECOND: cfg_nxt.sync_second = cfg_wdata;
        REG_SYNC_THIRD:  cfg_nxt.sync_third  = cfg_wdata;
        REG_END_FIRST:   cfg_nxt.end_first   = cfg_wdata;
        REG_END_SECOND:  cfg_nxt.end_second  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_ready   (in_ready),
    .q_stat     (q_stat),
    .back_busy  (back_busy),
    .push       (push),
    .job        (push_job),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  sfr_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .wr_data             (wr_data),
    .head                (head),
    .q_stat              (q_stat),
    .pop                 (pop),
    .busy                (back_busy),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_msg_class       (out_msg_class),
    .out_msg_kind        (out_msg_kind),
    .out_payload_len     (out_payload_len),
    .out_byte_index      (out_byte_index),
    .out_data_byte       (out_data_byte),
    .out_last            (out_last),
    .out_checksum_errors (out_checksum_errors),
    .out_header_errors   (out_header_errors)
  );

endmodule

### rtl/sfr_front.sv
// front end: takes received bytes, tracks framing and hunt state, checks frames
// depends on sfr_pkg; pushes frame jobs into sfr_queue and writes payload store

module sfr_front #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
  parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH_DEF,
  localparam int PW = $clog2(STORE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfr_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [sfr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                      in_ready,
  input  sfr_pkg::q_stat_t          q_stat,
  input  logic                      back_busy,
  output logic                      push,
  output sfr_pkg::job_t             job,
  output logic                      wr_en,
  output logic [PW-1:0]             wr_addr,
  output logic [sfr_pkg::BYTE_W-1:0] wr_data
);
  import sfr_pkg::*;

  logic [PW-1:0]     pos_r, pos_nxt, pos_inc;
  logic              hunting_r, hunting_nxt;
  logic              lk_r, lk_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [BYTE_W-1:0] cks_r, cks_nxt;
  logic [BYTE_W-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [CNT_W-1:0]  ccnt_r, ccnt_nxt, hcnt_r, hcnt_nxt;
  logic [BYTE_W-1:0] hdr_r [HEADER_BYTES];
  logic [BYTE_W-1:0] hdr_nxt [HEADER_BYTES];
  logic [BYTE_W-1:0] hsum;
  logic [RAW_W-1:0]  raw, raw_in;
  logic              accept, in_payload, good;
  logic [CMP_W-1:0]  pos_c;

  assign pos_c   = CMP_W'(pos_r);
  assign pos_inc = (pos_r == PW'(STORE_DEPTH - 1)) ? '0 : pos_r + 1'b1;
  assign in_ready = !q_stat.full &&
                    !((pos_c >= CMP_W'(HEADER_BYTES)) && (q_stat.has_good || back_busy));
  assign accept  = in_valid && in_ready;

  assign wr_en   = accept && (pos_c >= CMP_W'(HEADER_BYTES));
  assign wr_addr = pos_r;
  assign wr_data = in_rx_byte;

  assign raw    = {hdr_r[6], hdr_r[5]};
  assign raw_in = {in_rx_byte, hdr_r[5]};

  always_comb begin
    hsum = '0;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hsum = hsum + hdr_r[i];
    end
  end

  assign in_payload = lk_r && (pos_c >= CMP_W'(HEADER_BYTES)) &&
                      (pos_c < CMP_W'(len_r) + CMP_W'(HEADER_BYTES));

  assign good = (raw != '0) && (raw <= RAW_W'(MAX_PAYLOAD)) &&
                ((RAW_W + 1)'(HEADER_BYTES) + (RAW_W + 1)'(raw) <
                 (RAW_W + 1)'(STORE_DEPTH)) &&
                (BYTE_W'(hsum + acc_r) == cks_r);

  always_comb begin
    pos_nxt     = pos_r;
    hunting_nxt = hunting_r;
    lk_nxt      = lk_r;
    len_nxt     = len_r;
    acc_nxt     = acc_r;
    cks_nxt     = cks_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    ccnt_nxt    = ccnt_r;
    hcnt_nxt    = hcnt_r;
    hdr_nxt     = hdr_r;
    push        = 1'b0;
    job         = '0;
    if (accept) begin
      if (pos_c < CMP_W'(HEADER_BYTES)) begin
        hdr_nxt[pos_r[HIDX_W-1:0]] = in_rx_byte;
      end
      pos_nxt = pos_inc;
      if (!hunting_r) begin
        if (in_payload) begin
          acc_nxt = acc_r + in_rx_byte;
        end
        if (lk_r && (pos_c == CMP_W'(len_r) + CMP_W'(HEADER_BYTES))) begin
          cks_nxt = in_rx_byte;
        end
        if (pos_r == PW'(2)) begin
          hunting_nxt = 1'b1;
          if (!(hdr_r[0] == cfg.sync_first && hdr_r[1] == cfg.sync_second &&
                in_rx_byte == cfg.sync_third)) begin
            hcnt_nxt = hcnt_r + 1'b1;
          end
        end else if (pos_r == PW'(6)) begin
          len_nxt = (raw_in > RAW_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : raw_in[LEN_W-1:0];
          lk_nxt  = 1'b1;
          acc_nxt = '0;
        end
        if (lk_nxt && (pos_c >= CMP_W'(len_nxt) +
                                CMP_W'(HEADER_BYTES + TRAILER_BYTES - 1))) begin
          push          = 1'b1;
          job.msg_class = hdr_r[3];
          job.msg_kind  = hdr_r[4];
          job.plen      = len_nxt;
          if (good) begin
            job.status = STATUS_OK;
          end else begin
            job.status  = STATUS_ERR;
            hunting_nxt = 1'b1;
            ccnt_nxt    = ccnt_r + 1'b1;
          end
          job.cerr = ccnt_nxt;
          job.herr = hcnt_nxt;
          pos_nxt  = '0;
          lk_nxt   = 1'b0;
        end
      end
      if (hunting_nxt) begin
        if (p1_r == cfg.end_first && in_rx_byte == cfg.end_second) begin
          pos_nxt     = '0;
          hunting_nxt = 1'b0;
        end else if (p2_r == cfg.sync_first && p1_r == cfg.sync_second &&
                     in_rx_byte == cfg.sync_third) begin
          hdr_nxt[0]  = cfg.sync_first;
          hdr_nxt[1]  = cfg.sync_second;
          hdr_nxt[2]  = cfg.sync_third;
          pos_nxt     = PW'(3);
          hunting_nxt = 1'b0;
        end
      end
      p2_nxt = p1_r;
      p1_nxt = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hunting_r <= 1'b0;
      lk_r      <= 1'b0;
      len_r     <= '0;
      p1_r      <= '0;
      p2_r      <= '0;
      ccnt_r    <= '0;
      hcnt_r    <= '0;
    end else begin
      pos_r     <= pos_nxt;
      hunting_r <= hunting_nxt;
      lk_r      <= lk_nxt;
      len_r     <= len_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      ccnt_r    <= ccnt_nxt;
      hcnt_r    <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cks_r <= cks_nxt;
    hdr_r <= hdr_nxt;
  end

endmodule

### rtl/sfr_queue.sv
// short job queue between the front end and the result back end
// depends on sfr_pkg for the job and status types

module sfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfr_pkg::job_t    push_job,
  input  logic             pop,
  output sfr_pkg::job_t    head,
  output sfr_pkg::q_stat_t stat
);
  import sfr_pkg::*;

  job_t            ent_r [Q_DEPTH];
  logic [Q_PW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            good_any;
  logic [Q_PW-1:0] rel;

  assign head       = ent_r[rp_r];
  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.has_good = good_any;

  always_comb begin
    good_any = 1'b0;
    rel      = '0;
    for (int i = 0; i < Q_DEPTH; i++) begin
      rel = Q_PW'(i) - rp_r;
      if ((Q_CW'(rel) < cnt_r) && (ent_r[i].status == STATUS_OK)) begin
        good_any = 1'b1;
      end
    end
  end

  always_comb begin
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    cnt_nxt = cnt_r + Q_CW'(push) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      cnt_r <= '0;
    end else begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

endmodule

### rtl/sfr_back.sv
// back end: holds the payload store and turns frame jobs into result transactions
// depends on sfr_pkg; fed by sfr_queue, store written by sfr_front

module sfr_back #(
  parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH_DEF,
  localparam int PW = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [PW-1:0]              wr_addr,
  input  logic [sfr_pkg::BYTE_W-1:0] wr_data,
  input  sfr_pkg::job_t              head,
  input  sfr_pkg::q_stat_t           q_stat,
  output logic                       pop,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic [sfr_pkg::BYTE_W-1:0] out_msg_class,
  output logic [sfr_pkg::BYTE_W-1:0] out_msg_kind,
  output logic [sfr_pkg::LEN_W-1:0]  out_payload_len,
  output logic [sfr_pkg::IDX_W-1:0]  out_byte_index,
  output logic [sfr_pkg::BYTE_W-1:0] out_data_byte,
  output logic                       out_last,
  output logic [sfr_pkg::CNT_W-1:0]  out_checksum_errors,
  output logic [sfr_pkg::CNT_W-1:0]  out_header_errors
);
  import sfr_pkg::*;

  bk_state_t         state_r, state_nxt;
  job_t              job_r;
  logic [LEN_W-1:0]  idx_r, idx_step;
  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_en, load, step, last;
  logic [PW-1:0]     rd_addr;

  assign idx_step = idx_r + 1'b1;
  assign last     = (job_r.status == STATUS_ERR) || (idx_step == job_r.plen);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (head.status == STATUS_ERR) ? BK_SHOW : BK_FETCH;
        end
      end
      BK_FETCH: state_nxt = BK_SHOW;
      BK_SHOW: begin
        if (out_ready) begin
          state_nxt = last ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    step      = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = PW'(HEADER_BYTES);
    out_valid = 1'b0;
    busy      = 1'b1;
    case (state_r)
      BK_IDLE: begin
        busy  = 1'b0;
        load  = !q_stat.empty;
        rd_en = !q_stat.empty && (head.status == STATUS_OK);
      end
      BK_FETCH: ;
      BK_SHOW: begin
        out_valid = 1'b1;
        step      = out_ready && !last;
        rd_en     = step;
        rd_addr   = PW'(HEADER_BYTES) + PW'(idx_step);
      end
      default: busy = 1'b0;
    endcase
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= head;
      idx_r <= '0;
    end else if (step) begin
      idx_r <= idx_step;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_status          = job_r.status;
  assign out_msg_class       = job_r.msg_class;
  assign out_msg_kind        = job_r.msg_kind;
  assign out_payload_len     = job_r.plen;
  assign out_byte_index      = idx_r[IDX_W-1:0];
  assign out_data_byte       = (job_r.status == STATUS_ERR) ? '0 : rd_data_r;
  assign out_last            = last;
  assign out_checksum_errors = job_r.cerr;
  assign out_header_errors   = job_r.herr;

endmodule

### bench/tb.sv
// testbench for serial_frame_receiver_unit: byte stream in, frame results out
// predicts every result from its own copy of the deframing state; needs sfr_pkg and the rtl
`timescale 1ns / 100ps

module tb;
  import sfr_pkg::*;

  localparam int MAX_LEN     = MAX_PAYLOAD_DEF;
  localparam int STORE_LEN   = STORE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 50000;
  localparam int IDLE_PCT    = 13;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] cls;
    logic [BYTE_W-1:0] kind;
    logic [LEN_W-1:0]  plen;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  cerr;
    logic [CNT_W-1:0]  herr;
  } frame_rep_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_status;
  logic [BYTE_W-1:0]    out_msg_class;
  logic [BYTE_W-1:0]    out_msg_kind;
  logic [LEN_W-1:0]     out_payload_len;
  logic [IDX_W-1:0]     out_byte_index;
  logic [BYTE_W-1:0]    out_data_byte;
  logic                 out_last;
  logic [CNT_W-1:0]     out_checksum_errors;
  logic [CNT_W-1:0]     out_header_errors;

  logic [BYTE_W-1:0] rx_stream [$];
  frame_rep_t        frame_reports [$];

  // deframer shadow state
  cfg_t              markers = '0;
  logic [BYTE_W-1:0] rx_store [STORE_LEN];
  int                wr_pos = 0;
  bit                len_known = 1'b0;
  int                frame_len = 0;
  bit                hunting = 1'b0;
  logic [BYTE_W-1:0] prev_byte = '0;
  logic [BYTE_W-1:0] prev2_byte = '0;
  logic [CNT_W-1:0]  sum_errs = '0;
  logic [CNT_W-1:0]  hdr_errs = '0;

  bit calm = 1'b0;
  bit byte_taken = 1'b0;
  int errors = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int marker_sets = 0;
  int cycle_count = 0;

  serial_frame_receiver_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_msg_class       (out_msg_class),
    .out_msg_kind        (out_msg_kind),
    .out_payload_len     (out_payload_len),
    .out_byte_index      (out_byte_index),
    .out_data_byte       (out_data_byte),
    .out_last            (out_last),
    .out_checksum_errors (out_checksum_errors),
    .out_header_errors   (out_header_errors)
  );

  always #4 clk = ~clk;

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    int         raw;
    int         k;
    bit         good;
    logic [7:0] sum;
    frame_rep_t rep;
    rx_store[wr_pos] = b;
    if (!hunting) begin
      if (wr_pos == 2) begin
        hunting = 1'b1;
        if (rx_store[0] != markers.sync_first || rx_store[1] != markers.sync_second ||
            rx_store[2] != markers.sync_third)
          hdr_errs++;
      end else if (wr_pos == 6) begin
        raw = int'({rx_store[6], rx_store[5]});
        frame_len = (raw > MAX_LEN) ? MAX_LEN : raw;
        len_known = 1'b1;
      end
      if (len_known && wr_pos >= frame_len + HEADER_BYTES + TRAILER_BYTES - 1) begin
        raw = int'({rx_store[6], rx_store[5]});
        good = 1'b0;
        if (raw > 0 && raw <= MAX_LEN && HEADER_BYTES + raw < STORE_LEN) begin
          sum = 8'h00;
          for (k = 0; k < HEADER_BYTES + raw; k++)
            sum = sum + rx_store[k];
          good = (sum == rx_store[HEADER_BYTES + raw]);
        end
        rep.cls  = rx_store[3];
        rep.kind = rx_store[4];
        rep.plen = LEN_W'(frame_len);
        if (!good) begin
          hunting = 1'b1;
          sum_errs++;
          rep.status = STATUS_ERR;
          rep.idx    = '0;
          rep.data   = '0;
          rep.last   = 1'b1;
          rep.cerr   = sum_errs;
          rep.herr   = hdr_errs;
          frame_reports.push_back(rep);
        end else begin
          for (k = 0; k < raw; k++) begin
            rep.status = STATUS_OK;
            rep.idx    = IDX_W'(k);
            rep.data   = rx_store[HEADER_BYTES + k];
            rep.last   = (k == raw - 1);
            rep.cerr   = sum_errs;
            rep.herr   = hdr_errs;
            frame_reports.push_back(rep);
          end
        end
        wr_pos = STORE_LEN - 1;
        len_known = 1'b0;
      end
    end
    wr_pos = (wr_pos + 1) % STORE_LEN;
    if (hunting) begin
      if (prev_byte == markers.end_first && b == markers.end_second) begin
        wr_pos = 0;
        hunting = 1'b0;
      end else if (prev2_byte == markers.sync_first && prev_byte == markers.sync_second &&
                   b == markers.sync_third) begin
        rx_store[0] = markers.sync_first;
        rx_store[1] = markers.sync_second;
        rx_store[2] = markers.sync_third;
        wr_pos = 3;
        hunting = 1'b0;
      end
    end
    prev2_byte = prev_byte;
    prev_byte = b;
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || byte_taken) begin
        if (rx_stream.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : monitor
    frame_rep_t want;
    byte_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (frame_reports.size() == 0) begin
          errors++;
          $display("%0t ns: result transaction with none expected, got status %0b data %0h",
                   $time, out_status, out_data_byte);
        end else begin
          want = frame_reports.pop_front();
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("msg_class", 16'(want.cls), 16'(out_msg_class));
          check_field("msg_kind", 16'(want.kind), 16'(out_msg_kind));
          check_field("payload_len", 16'(want.plen), 16'(out_payload_len));
          check_field("byte_index", 16'(want.idx), 16'(out_byte_index));
          check_field("data_byte", 16'(want.data), 16'(out_data_byte));
          check_field("last", 16'(want.last), 16'(out_last));
          check_field("checksum_errors", want.cerr, out_checksum_errors);
          check_field("header_errors", want.herr, out_header_errors);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SYNC_FIRST:  markers.sync_first = val;
      REG_SYNC_SECOND: markers.sync_second = val;
      REG_SYNC_THIRD:  markers.sync_third = val;
      REG_END_FIRST:   markers.end_first = val;
      REG_END_SECOND:  markers.end_second = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_markers(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3,
                             input logic [7:0] e1, input logic [7:0] e2);
    write_reg(REG_SYNC_FIRST, s1);
    write_reg(REG_SYNC_SECOND, s2);
    write_reg(REG_SYNC_THIRD, s3);
    write_reg(REG_END_FIRST, e1);
    write_reg(REG_END_SECOND, e2);
    marker_sets++;
  endtask

  task automatic drain(input int settle);
    while (rx_stream.size() != 0 || in_valid || frame_reports.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // sync, ids, length, payload, checksum, trailer; payload count follows the clamped length
  task automatic push_frame(input logic [7:0] cls, input logic [7:0] kind,
                            input logic [15:0] len_field, input bit corrupt, input bit proper_end);
    int         n;
    int         k;
    logic [7:0] sum;
    logic [7:0] pb;
    n = (len_field > MAX_LEN) ? MAX_LEN : len_field;
    sum = markers.sync_first + markers.sync_second + markers.sync_third + cls + kind +
          len_field[7:0] + len_field[15:8];
    queue_byte(markers.sync_first);
    queue_byte(markers.sync_second);
    queue_byte(markers.sync_third);
    queue_byte(cls);
    queue_byte(kind);
    queue_byte(len_field[7:0]);
    queue_byte(len_field[15:8]);
    for (k = 0; k < n; k++) begin
      pb = 8'($urandom);
      queue_byte(pb);
      sum = sum + pb;
    end
    pb = corrupt ? 8'($urandom_range(255, 1)) : 8'h00;
    queue_byte(sum + pb);
    queue_byte(proper_end ? markers.end_first : 8'($urandom));
    queue_byte(proper_end ? markers.end_second : 8'($urandom));
  endtask

  task automatic push_traffic(input int target);
    int          start;
    int          pick;
    int          k;
    logic [15:0] len;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = 16'(($urandom_range(9) == 0) ? MAX_LEN : $urandom_range(6, 1));
        push_frame(8'($urandom), 8'($urandom), len, 1'b0, 1'b1);
      end else if (pick < 62) begin
        push_frame(8'($urandom), 8'($urandom), 16'($urandom_range(8, 1)), 1'b1, 1'b1);
      end else if (pick < 70) begin
        case ($urandom_range(2))
          0: len = 16'h0000;
          1: len = 16'($urandom_range(255, MAX_LEN + 1));
          default: len = {8'($urandom_range(255, 1)), 8'($urandom)};
        endcase
        push_frame(8'($urandom), 8'($urandom), len, 1'($urandom_range(1)), 1'b1);
      end else if (pick < 78) begin
        for (k = 0; k < 3; k++)
          queue_byte(8'($urandom));
        if ($urandom_range(1)) begin
          queue_byte(markers.end_first);
          queue_byte(markers.end_second);
        end
      end else if (pick < 88) begin
        for (k = $urandom_range(5, 1); k > 0; k--)
          queue_byte(8'($urandom));
      end else begin
        push_frame(8'($urandom), 8'($urandom), 16'($urandom_range(6, 1)),
                   1'($urandom_range(1)), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset markers are all zero: a zero header also matches the terminator pair
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h00);
    drain(16);

    set_markers(8'hB5, 8'h62, 8'h01, 8'h0D, 8'h0A);
    write_reg(REG_UNUSED, 8'($urandom));
    push_frame(8'hFF, 8'h00, 16'(MAX_LEN), 1'b0, 1'b1);
    push_frame(8'h12, 8'h34, 16'd0, 1'b0, 1'b1);
    push_frame(8'h9A, 8'hBC, 16'd1, 1'b1, 1'b1);
    // broken header, back in step on the terminator pair
    queue_byte(8'h00);
    queue_byte(8'h11);
    queue_byte(8'h22);
    queue_byte(markers.end_first);
    queue_byte(markers.end_second);
    push_frame(8'h01, 8'h02, 16'd1, 1'b0, 1'b1);
    // broken header, back in step on the sync bytes of the next frame
    for (k = 0; k < 3; k++)
      queue_byte(8'hAA);
    push_frame(8'h03, 8'h04, 16'd1, 1'b0, 1'b1);
    drain(16);

    set_markers(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    calm = 1'b1;
    push_traffic(12);
    drain(16);

    // terminator pair equal to the last two sync bytes: good headers restart the frame
    set_markers(8'hAA, 8'h55, 8'h33, 8'h55, 8'h33);
    push_traffic(12);
    drain(100);
    calm = 1'b0;

    $display("checked %0d result transactions against %0d received bytes", results_seen,
             bytes_taken);
    $display("%0d marker settings; good, bad checksum, bad length and broken header frames",
             marker_sets);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
